// ----- rtl/rthsl_pkg.sv -----
package rthsl_pkg;

    localparam int CHAN_W  = 8;
    localparam int QUO_W   = 17;
    localparam int DEN_W   = CHAN_W;
    localparam int NUM_W   = QUO_W + DEN_W;
    localparam int HNUM_W  = 11;
    localparam int Q15_W   = 16;
    localparam int SUM_W   = CHAN_W + 1;

    // One restoring-division step: partial remainder, numerator bits left, quotient so far.
    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [QUO_W-1:0] nlow;
        logic [QUO_W-1:0] quo;
        logic [DEN_W-1:0] den;
    } div_stage_t;

endpackage

// ----- rtl/rthsl_div.sv -----
module rthsl_div
    import rthsl_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo
);

    div_stage_t stage_reg [QUO_W];
    div_stage_t stage_in  [QUO_W];
    div_stage_t stage_next[QUO_W];

    always_comb
    begin
        stage_in[0].rem  = num[NUM_W-1:QUO_W];
        stage_in[0].nlow = num[QUO_W-1:0];
        stage_in[0].quo  = '0;
        stage_in[0].den  = den;
        for (int k = 1; k < QUO_W; k++)
        begin
            stage_in[k] = stage_reg[k-1];
        end
    end

    // One quotient bit per stage, most significant first.
    always_comb
    begin
        logic [DEN_W:0] trial;
        logic           ge;
        for (int k = 0; k < QUO_W; k++)
        begin
            trial = {stage_in[k].rem, stage_in[k].nlow[QUO_W-1]};
            ge    = (trial >= {1'b0, stage_in[k].den});
            stage_next[k].rem  = ge ? DEN_W'(trial - {1'b0, stage_in[k].den})
                                    : trial[DEN_W-1:0];
            stage_next[k].nlow = {stage_in[k].nlow[QUO_W-2:0], 1'b0};
            stage_next[k].quo  = {stage_in[k].quo[QUO_W-2:0], ge};
            stage_next[k].den  = stage_in[k].den;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < QUO_W; k++)
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    assign quo = stage_reg[QUO_W-1].quo;

endmodule

// ----- rtl/rgb_to_hsl_converter_core.sv -----
// Channel | Handshake                  | Fields
// pixel   | pixel_valid / pixel_stall  | red, green, blue (8 bits each)
// hsl     | hsl_valid / hsl_stall      | hue (17), saturation (16), lightness (16)
//
// One pixel per cycle unless stalled, through 20 register stages: input register,
// min/max stage, 17 stages of the bit-per-stage dividers, output register.
// Reset clears all valid bits; data registers are not reset.
// A stall on hsl while hsl_valid is high freezes the whole pipeline and is passed back to pixel_stall.
module rgb_to_hsl_converter_core
    import rthsl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pixel_valid,
    output logic              pixel_stall,
    input  logic [CHAN_W-1:0] red,
    input  logic [CHAN_W-1:0] green,
    input  logic [CHAN_W-1:0] blue,
    output logic              hsl_valid,
    input  logic              hsl_stall,
    output logic [QUO_W-1:0]  hue,
    output logic [Q15_W-1:0]  saturation,
    output logic [Q15_W-1:0]  lightness
);

    localparam int DEPTH = QUO_W + 3;

    logic              en;
    logic [DEPTH-1:0]  valid_reg;
    logic [CHAN_W-1:0] r_reg, g_reg, b_reg;
    logic [NUM_W-1:0]  hnum_reg, snum_reg;
    logic [DEN_W-1:0]  den_reg, sden_reg;
    logic [Q15_W-1:0]  light_reg [QUO_W+2];
    logic [QUO_W-1:0]  hue_quo, sat_quo;
    logic [QUO_W-1:0]  hue_reg;
    logic [Q15_W-1:0]  sat_reg;

    logic [CHAN_W-1:0] mx, mn, d;
    logic [SUM_W-1:0]  s, s_inv;
    logic [HNUM_W-1:0] hnum, d_ext;
    logic [Q15_W-1:0]  y, light_next;
    logic [DEN_W-1:0]  sden;

    assign en          = !(hsl_valid && hsl_stall);
    assign pixel_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[DEPTH-2:0], pixel_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg <= red;
            g_reg <= green;
            b_reg <= blue;
        end
    end

    always_comb
    begin
        mx = r_reg;
        mn = r_reg;
        if (g_reg > mx) mx = g_reg;
        if (b_reg > mx) mx = b_reg;
        if (g_reg < mn) mn = g_reg;
        if (b_reg < mn) mn = b_reg;
        d     = mx - mn;
        s     = SUM_W'(mx) + SUM_W'(mn);
        s_inv = SUM_W'(510) - s;
        d_ext = HNUM_W'(d);
        if (mx == r_reg)
        begin
            if (g_reg >= b_reg)
                hnum = HNUM_W'(g_reg) - HNUM_W'(b_reg);
            else
                hnum = HNUM_W'(6) * d_ext + HNUM_W'(g_reg) - HNUM_W'(b_reg);
        end
        else if (mx == g_reg)
        begin
            hnum = HNUM_W'(2) * d_ext + HNUM_W'(b_reg) - HNUM_W'(r_reg);
        end
        else
        begin
            hnum = HNUM_W'(4) * d_ext + HNUM_W'(r_reg) - HNUM_W'(g_reg);
        end
        // gray: numerators are zero, keep the divisor nonzero
        if (d == '0)
            sden = DEN_W'(1);
        else if (s < SUM_W'(255))
            sden = s[DEN_W-1:0];
        else
            sden = s_inv[DEN_W-1:0];
        // s*16384/255 = 64s + floor(64s/255)
        y          = Q15_W'({s, 6'b0});
        light_next = y + Q15_W'((17'(y) + 17'(y >> 8) + 17'd1) >> 8);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hnum_reg     <= (NUM_W'(hnum) << 14) - (NUM_W'(hnum) << 10);
            snum_reg     <= NUM_W'(d) << 15;
            den_reg      <= (d == '0) ? DEN_W'(1) : d;
            sden_reg     <= sden;
            light_reg[0] <= light_next;
            for (int k = 1; k <= QUO_W + 1; k++)
            begin
                light_reg[k] <= light_reg[k-1];
            end
            hue_reg <= hue_quo;
            sat_reg <= sat_quo[Q15_W-1:0];
        end
    end

    rthsl_div u_hue_div
    (
        .clk (clk),
        .en  (en),
        .num (hnum_reg),
        .den (den_reg),
        .quo (hue_quo)
    );

    rthsl_div u_sat_div
    (
        .clk (clk),
        .en  (en),
        .num (snum_reg),
        .den (sden_reg),
        .quo (sat_quo)
    );

    assign hsl_valid  = valid_reg[DEPTH-1];
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign lightness  = light_reg[QUO_W+1];

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        hsl_valid |-> hue <= QUO_W'(92159))
        else $error("hue out of range");

    a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
        hsl_valid |-> saturation <= Q15_W'(32768))
        else $error("saturation out of range");

    a_light_range: assert property (@(posedge clk) disable iff (!rst_n)
        hsl_valid |-> lightness <= Q15_W'(32768))
        else $error("lightness out of range");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |=> $stable(valid_reg))
        else $error("pipeline moved during stall");

endmodule

// ----- bench/rgb_to_hsl_converter_core_test.sv -----
`timescale 1ns / 1ps

module rgb_to_hsl_converter_core_test;
    import rthsl_pkg::*;

    typedef struct {
        logic [QUO_W-1:0] hue;
        logic [Q15_W-1:0] saturation;
        logic [Q15_W-1:0] lightness;
    } hsl_t;

    class hsl_scoreboard;
        hsl_t pending[$];
        int errors = 0;

        function hsl_t convert(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            int unsigned mx, mn, d, s, num;
            hsl_t res;
            mx = r; mn = r;
            if (g > mx) mx = g;
            if (b > mx) mx = b;
            if (g < mn) mn = g;
            if (b < mn) mn = b;
            d = mx - mn;
            s = mx + mn;
            res.lightness = (s * 32768) / 510;
            res.saturation = '0;
            res.hue = '0;
            if (d != 0)
            begin
                res.saturation = (s < 255) ? (d * 32768) / s : (d * 32768) / (510 - s);
                if (mx == r)
                    num = (g >= b) ? g - b : 6 * d + g - b;
                else if (mx == g)
                    num = 2 * d + b - r;
                else
                    num = 4 * d + r - g;
                res.hue = (15360 * num) / d;
            end
            return res;
        endfunction

        function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            pending.push_back(convert(r, g, b));
        endfunction

        function void check_hsl(logic [QUO_W-1:0] h, logic [Q15_W-1:0] s,
                                logic [Q15_W-1:0] l);
            hsl_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected hsl transfer hue=%0d sat=%0d light=%0d", h, s, l);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (h !== want.hue)
            begin
                $error("hue expected %0d actual %0d", want.hue, h);
                errors++;
            end
            if (s !== want.saturation)
            begin
                $error("saturation expected %0d actual %0d", want.saturation, s);
                errors++;
            end
            if (l !== want.lightness)
            begin
                $error("lightness expected %0d actual %0d", want.lightness, l);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic pixel_valid = 0;
    logic pixel_stall;
    logic [CHAN_W-1:0] red = 0, green = 0, blue = 0;
    logic hsl_valid;
    logic hsl_stall = 0;
    logic [QUO_W-1:0] hue;
    logic [Q15_W-1:0] saturation, lightness;
    bit steady = 0;

    hsl_scoreboard board = new();

    rgb_to_hsl_converter_core dut (.*);

    always
    begin
        #2 clk = 1;
        #2 clk = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n && pixel_valid && !pixel_stall)
            board.note_pixel(red, green, blue);
        if (rst_n && hsl_valid && !hsl_stall)
            board.check_hsl(hue, saturation, lightness);
    end

    // Receiver stall, quiet during the steady stretch.
    always @(negedge clk)
        hsl_stall <= !steady && ($urandom_range(99) < 8);

    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        while (!steady && $urandom_range(99) < 8)
        begin
            pixel_valid <= 0;
            @(negedge clk);
        end
        pixel_valid <= 1;
        red <= r;
        green <= g;
        blue <= b;
        @(posedge clk);
        while (pixel_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain;
        pixel_valid <= 0;
        while (board.pending.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        logic [7:0] r, g, b;
        repeat (2) @(negedge clk);
        rst_n = 1;
        @(negedge clk);
        // Extremes, gray pixels, each channel as maximum, ties and the hue wrap.
        send_pixel(0, 0, 0);
        send_pixel(255, 255, 255);
        send_pixel(128, 128, 128);
        send_pixel(255, 0, 0);
        send_pixel(0, 255, 0);
        send_pixel(0, 0, 255);
        send_pixel(255, 0, 1);
        send_pixel(255, 1, 0);
        send_pixel(255, 255, 0);
        send_pixel(0, 255, 255);
        send_pixel(255, 0, 255);
        send_pixel(1, 0, 0);
        send_pixel(254, 255, 255);
        send_pixel(127, 128, 127);
        send_pixel(128, 127, 127);
        send_pixel(10, 200, 100);
        send_pixel(50, 20, 240);
        send_pixel(200, 30, 90);
        send_pixel(170, 85, 170);
        send_pixel(1, 254, 128);
        drain();
        for (int i = 0; i < 1550; i++)
        begin
            steady = (i >= 500 && i < 700);
            r = $urandom;
            g = $urandom;
            b = $urandom;
            case ($urandom_range(5))
                0: g = r;
                1: b = g;
                2: begin g = r; b = r; end
                3: begin g = r + $urandom_range(2); b = r - $urandom_range(2); end
                default: ;
            endcase
            send_pixel(r, g, b);
            if (i == 900)
                drain();
        end
        steady = 0;
        drain();
        repeat (40) @(negedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("rgb_to_hsl_converter_core_test OK");
        else
            $display("rgb_to_hsl_converter_core_test NOT OK");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("rgb_to_hsl_converter_core_test NOT OK");
        $finish;
    end
endmodule

// ----- files.f -----
rtl/rthsl_pkg.sv
rtl/rthsl_div.sv
rtl/rgb_to_hsl_converter_core.sv
bench/rgb_to_hsl_converter_core_test.sv
